/* design/pdg_pkg.sv */
// shared types, widths and register codes for the pd drive with gyro steering
package pdg_pkg;

    // field widths
    localparam int POS_W   = 16;
    localparam int HEAD_W  = 16;
    localparam int DT_W    = 8;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 20;
    localparam int BAND_W  = 15;
    localparam int OUT_W   = 8;

    // internal widths, sized for the largest nominal period
    localparam int ERR_W   = POS_W + 1;
    localparam int DIFF_W  = POS_W + 2;
    localparam int SUM_W   = 24;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 42;
    localparam int ACC_W   = 44;
    localparam int P_W     = ACC_W - 8;
    localparam int PC_W    = P_W + 2;
    localparam int CNT_W   = $clog2(NUM_W);

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = LIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RUN    = 4'd7;

    // register reset values
    localparam logic [GAIN_W-1:0] PROP_RST  = 16'd61;
    localparam logic [GAIN_W-1:0] DERIV_RST = 16'd41;
    localparam logic [LIM_W-1:0]  LIMIT_RST = 20'hFFFFF;

    typedef struct packed {
        logic signed [POS_W-1:0] target;
        logic [GAIN_W-1:0]       prop;
        logic [GAIN_W-1:0]       integ;
        logic [GAIN_W-1:0]       deriv;
        logic [GAIN_W-1:0]       steer;
        logic [LIM_W-1:0]        limit;
        logic [BAND_W-1:0]       band;
        logic                    run;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic err;
        logic mul_dn;
        logic mul_d;
        logic div_ld;
        logic div_step;
        logic mul_p;
        logic mul_i;
        logic mul_c;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic done_flag;
    } t_stat;

endpackage

/* design/pdg_tick_if.sv */
// tick channel: position, heading and elapsed time
interface pdg_tick_if;
    logic                            valid;
    logic                            ready;
    logic signed [pdg_pkg::POS_W-1:0]  position_sample;
    logic signed [pdg_pkg::HEAD_W-1:0] heading_sample;
    logic [pdg_pkg::DT_W-1:0]          elapsed_ms;

    modport source (output valid, position_sample, heading_sample, elapsed_ms, input ready);
    modport sink (input valid, position_sample, heading_sample, elapsed_ms, output ready);
endinterface

/* design/pdg_res_if.sv */
// result channel: motor commands and finish flag
interface pdg_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [pdg_pkg::OUT_W-1:0] left_power;
    logic signed [pdg_pkg::OUT_W-1:0] right_power;
    logic                             move_done;

    modport source (output valid, left_power, right_power, move_done, input ready);
    modport sink (input valid, left_power, right_power, move_done, output ready);
endinterface

/* design/pdg_cfg.sv */
// configuration register file
module pdg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pdg_pkg::t_cfg                     o_cfg
);
    import pdg_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= '0;
            r_cfg.prop   <= PROP_RST;
            r_cfg.integ  <= '0;
            r_cfg.deriv  <= DERIV_RST;
            r_cfg.steer  <= '0;
            r_cfg.limit  <= LIMIT_RST;
            r_cfg.band   <= '0;
            r_cfg.run    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET: r_cfg.target <= $signed(i_cfg_data[POS_W-1:0]);
                REG_PROP:   r_cfg.prop   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG:  r_cfg.integ  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV:  r_cfg.deriv  <= i_cfg_data[GAIN_W-1:0];
                REG_STEER:  r_cfg.steer  <= i_cfg_data[GAIN_W-1:0];
                REG_LIMIT:  r_cfg.limit  <= i_cfg_data[LIM_W-1:0];
                REG_BAND:   r_cfg.band   <= i_cfg_data[BAND_W-1:0];
                REG_RUN:    r_cfg.run    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/pdg_dp.sv */
// datapath: error, integral, shared multiplier, divider, steering and output register
module pdg_dp #(
    parameter int STEER_DEADBAND    = 10,
    parameter int POWER_LIMIT       = 127,
    parameter int NOMINAL_PERIOD_MS = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdg_pkg::t_cfg                       i_cfg,
    input  pdg_pkg::t_cmd                       i_cmd,
    output pdg_pkg::t_stat                      o_stat,
    input  logic signed [pdg_pkg::POS_W-1:0]    i_pos,
    input  logic signed [pdg_pkg::HEAD_W-1:0]   i_head,
    input  logic [pdg_pkg::DT_W-1:0]            i_dt,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pdg_pkg::OUT_W-1:0]    o_left,
    output logic signed [pdg_pkg::OUT_W-1:0]    o_right,
    output logic                                o_done
);
    import pdg_pkg::*;

    localparam int OUT_LIM = (POWER_LIMIT > 127) ? 127 : POWER_LIMIT;
    localparam logic signed [PC_W-1:0]    LIM_P  = PC_W'(OUT_LIM);
    localparam logic signed [PC_W-1:0]    LIM_N  = -LIM_P;
    localparam logic signed [PC_W-1:0]    PWR    = PC_W'(POWER_LIMIT);
    localparam logic signed [HEAD_W:0]    DB_P   = (HEAD_W + 1)'(STEER_DEADBAND);
    localparam logic signed [HEAD_W:0]    DB_N   = -DB_P;
    localparam logic signed [MUL_W-1:0]   PERIOD = MUL_W'(NOMINAL_PERIOD_MS);
    localparam logic signed [SUM_W:0]     SUM_MAX = {2'b00, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W:0]     SUM_MIN = {2'b11, {(SUM_W - 1){1'b0}}};

    // saturate a command to the motor range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PC_W-1:0] x);
        logic signed [OUT_W-1:0] y;
        if (x > LIM_P) begin
            y = LIM_P[OUT_W-1:0];
        end else if (x < LIM_N) begin
            y = LIM_N[OUT_W-1:0];
        end else begin
            y = x[OUT_W-1:0];
        end
        return y;
    endfunction

    logic signed [POS_W-1:0]  r_pos;
    logic signed [HEAD_W-1:0] r_head;
    logic [DT_W-1:0]          r_dt;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_gain_off;
    logic signed [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]         r_quo;
    logic [DT_W-1:0]          r_rem;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [OUT_W-1:0]  r_held_l;
    logic signed [OUT_W-1:0]  r_held_r;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_l;
    logic signed [OUT_W-1:0]  r_out_r;
    logic                     r_out_done;

    // error, difference and integral update
    logic signed [ERR_W-1:0]  w_err;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SUM_W:0]    w_sum;
    logic signed [SUM_W-1:0]  w_sum_sat;
    logic                     w_over;

    assign w_err  = ERR_W'(i_cfg.target) - ERR_W'(r_pos);
    assign w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev);
    assign w_sum  = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(w_err);
    assign w_over = (SUM_W + 1)'(r_sum) > $signed({{(SUM_W + 1 - LIM_W){1'b0}}, i_cfg.limit});

    always_comb begin
        if (w_sum > SUM_MAX) begin
            w_sum_sat = SUM_MAX[SUM_W-1:0];
        end else if (w_sum < SUM_MIN) begin
            w_sum_sat = SUM_MIN[SUM_W-1:0];
        end else begin
            w_sum_sat = w_sum[SUM_W-1:0];
        end
    end

    // shared multiplier operand select
    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [GAIN_W-1:0]        w_ki;

    assign w_ki = r_gain_off ? '0 : i_cfg.integ;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (i_cmd.mul_dn) begin
            w_ma = $signed({{(MUL_W - GAIN_W){1'b0}}, i_cfg.deriv});
            w_mb = PERIOD;
        end else if (i_cmd.mul_d) begin
            w_ma = MUL_W'(r_diff);
            w_mb = $signed({1'b0, r_prod[MUL_W-2:0]});
        end else if (i_cmd.mul_p) begin
            w_ma = MUL_W'(r_err);
            w_mb = $signed({{(MUL_W - GAIN_W){1'b0}}, i_cfg.prop});
        end else if (i_cmd.mul_i) begin
            w_ma = MUL_W'(r_sum);
            w_mb = $signed({{(MUL_W - GAIN_W){1'b0}}, w_ki});
        end else if (i_cmd.mul_c) begin
            w_ma = MUL_W'(r_head);
            w_mb = $signed({{(MUL_W - GAIN_W){1'b0}}, i_cfg.steer});
        end
    end

    assign w_prod = w_ma * w_mb;

    // restoring divider step, one quotient bit a cycle
    logic [DT_W:0]            w_trial;
    logic                     w_ge;
    logic [DT_W:0]            w_trial_sub;
    logic [PROD_W-1:0]        w_mag;
    logic signed [ACC_W-1:0]  w_quo_ext;

    assign w_trial     = {r_rem, r_quo[NUM_W-1]};
    assign w_ge        = w_trial >= {1'b0, r_dt};
    assign w_trial_sub = w_trial - {1'b0, r_dt};
    assign w_mag       = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_quo_ext   = $signed({{(ACC_W - NUM_W){1'b0}}, r_quo});

    // steering and saturation
    logic signed [P_W-1:0]   w_p;
    logic signed [P_W-1:0]   w_c;
    logic signed [PC_W-1:0]  w_pw;
    logic signed [PC_W-1:0]  w_pc;
    logic signed [PC_W-1:0]  w_pm;
    logic signed [PC_W-1:0]  w_s;
    logic signed [HEAD_W:0]  w_head;
    logic signed [OUT_W-1:0] w_left;
    logic signed [OUT_W-1:0] w_right;
    logic [ERR_W-1:0]        w_emag;
    logic                    w_done_now;

    assign w_p    = r_acc[ACC_W-1:8];
    assign w_c    = r_prod[P_W+7:8];
    assign w_pw   = PC_W'(w_p);
    assign w_pc   = PC_W'(w_p) + PC_W'(w_c);
    assign w_pm   = PC_W'(w_p) - PC_W'(w_c);
    assign w_s    = w_pc[PC_W-1] ? -w_pc : w_pc;
    assign w_head = (HEAD_W + 1)'(r_head);
    assign w_emag = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_done_now = w_emag < {{(ERR_W - BAND_W){1'b0}}, i_cfg.band};

    always_comb begin
        w_left  = r_held_l;
        w_right = r_held_r;
        if (w_head > DB_P) begin
            if (w_s > PWR) begin
                w_right = sat_out(w_pm);
                w_left  = sat_out(w_pw);
            end else if (w_s < PWR) begin
                w_right = sat_out(w_pw);
                w_left  = sat_out(w_pc);
            end
        end else if (w_head < DB_N) begin
            if (w_s > PWR) begin
                w_right = sat_out(w_pw);
                w_left  = sat_out(w_pm);
            end else if (w_s < PWR) begin
                w_right = sat_out(w_pc);
                w_left  = sat_out(w_pw);
            end
        end else begin
            w_right = sat_out(w_pw);
            w_left  = sat_out(w_pw);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= i_pos;
            r_head <= i_head;
            r_dt   <= (i_dt == '0) ? DT_W'(1) : i_dt;
        end
        if (i_cmd.err) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
        if (i_cmd.mul_dn || i_cmd.mul_d || i_cmd.mul_p || i_cmd.mul_i || i_cmd.mul_c) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_ld) begin
            r_quo <= w_mag[NUM_W-1:0];
            r_rem <= '0;
            r_neg <= r_prod[PROD_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[DT_W-1:0] : w_trial[DT_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
        // accumulate quotient, proportional and integral terms
        if (i_cmd.mul_p) begin
            r_acc <= r_neg ? -w_quo_ext : w_quo_ext;
        end else if (i_cmd.mul_i || i_cmd.mul_c) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_l    <= w_left;
            r_out_r    <= w_right;
            r_out_done <= w_done_now;
        end
    end

    // loop state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_sum       <= '0;
            r_gain_off  <= 1'b0;
            r_done      <= 1'b0;
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.err) begin
                r_prev <= w_err;
                if (w_over) begin
                    r_gain_off <= 1'b1;
                end else begin
                    r_sum <= w_sum_sat;
                end
            end
            if (i_cmd.emit) begin
                r_held_l    <= w_left;
                r_held_r    <= w_right;
                r_out_valid <= 1'b1;
                if (w_done_now) begin
                    r_done <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_stat.done_flag = r_done;
    assign o_valid = r_out_valid;
    assign o_left  = r_out_l;
    assign o_right = r_out_r;
    assign o_done  = r_out_done;

    // latched flags only clear on reset
    a_gain_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain_off |=> r_gain_off) else $error("integral gain latch cleared");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done) else $error("done flag cleared");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && r_held_l == r_out_l && r_held_r == r_out_r))
        else $error("emitted result not presented");

endmodule

/* design/pdg_ctrl.sv */
// controller: sequences one tick through the datapath
module pdg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_run,
    input  pdg_pkg::t_stat   i_stat,
    output pdg_pkg::t_cmd    o_cmd
);
    import pdg_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_MUL_DN = 4'd2;
    localparam logic [3:0] S_MUL_D  = 4'd3;
    localparam logic [3:0] S_DIV_LD = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_MUL_P  = 4'd6;
    localparam logic [3:0] S_MUL_I  = 4'd7;
    localparam logic [3:0] S_MUL_C  = 4'd8;
    localparam logic [3:0] S_STEER  = 4'd9;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_run && !i_stat.done_flag) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MUL_DN;
            end
            S_MUL_DN: begin
                o_cmd.mul_dn = 1'b1;
                n_state      = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_DIV_LD;
            end
            S_DIV_LD: begin
                o_cmd.div_ld = 1'b1;
                n_cnt        = DIV_LAST;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL_P;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MUL_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.mul_i = 1'b1;
                n_state     = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_STEER;
            end
            S_STEER: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // fixed latency from transfer in to steering
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> ##(NUM_W + 8) (r_state == S_STEER)) else $error("tick latency off");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_ld |=> (r_state == S_DIV && r_cnt == DIV_LAST)) else $error("divider start");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE && !$past(i_stat.done_flag)))
        else $error("emit sequencing");

endmodule

/* design/pd_drive_with_gyro_steer.sv */
// top level: pd drive with gyro steering
//
//  channel   dir  handshake      payload
//  i_tick    in   valid/ready    position_sample, heading_sample, elapsed_ms
//  o_res     out  valid/ready    left_power, right_power, move_done
//  i_cfg_*   in   write enable   register index, write data
//
// a tick passes from transfer in to result through the 42-step restoring divider
// for the derivative term and five passes through the shared 25x25 multiplier;
// one tick is in flight at a time.
// a tick taken while not running or after finishing is dropped.
// reset is synchronous and clears the loop state; there is no clearing pass.
// a result waits in the output register while the next tick is taken in; the
// controller stalls only if that register is still full when the next result is due.
module pd_drive_with_gyro_steer #(
    parameter int STEER_DEADBAND    = 10,
    parameter int POWER_LIMIT       = 127,
    parameter int NOMINAL_PERIOD_MS = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pdg_tick_if.sink                          i_tick,
    pdg_res_if.source                         o_res
);
    import pdg_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // configuration registers
    pdg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // sequencer
    pdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .o_in_ready (w_in_ready),
        .i_run      (w_cfg.run),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic and output register
    pdg_dp #(
        .STEER_DEADBAND    (STEER_DEADBAND),
        .POWER_LIMIT       (POWER_LIMIT),
        .NOMINAL_PERIOD_MS (NOMINAL_PERIOD_MS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_pos   (i_tick.position_sample),
        .i_head  (i_tick.heading_sample),
        .i_dt    (i_tick.elapsed_ms),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_left  (o_res.left_power),
        .o_right (o_res.right_power),
        .o_done  (o_res.move_done)
    );

    assign i_tick.ready = w_in_ready;

endmodule
